/* sv/cscr_pkg.sv */
package cscr_pkg;
	localparam logic [1:0] CMD_ACCESS = 2'd0;
	localparam logic [1:0] CMD_EVICT  = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [2:0] ST_HIT       = 3'd0;
	localparam logic [2:0] ST_INSERTED  = 3'd1;
	localparam logic [2:0] ST_EVICTED   = 3'd2;
	localparam logic [2:0] ST_REMOVED   = 3'd3;
	localparam logic [2:0] ST_NOT_FOUND = 3'd4;
	localparam logic [2:0] ST_EMPTY     = 3'd5;
	localparam logic [2:0] ST_FULL      = 3'd6;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture command word
		logic scan_start;  // reset scan pointer
		logic scan_step;   // examine one slot
		logic insert;      // link new key at tail
		logic hand_init;   // place hand if unset
		logic sweep_step;  // one step of the clock hand
		logic unlink;      // unlink the target slot
		logic hit_mark;    // set reference bit of target
		logic fetch;       // latch links of target
		logic victim_cap;  // capture victim key
	} cscr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [1:0] command;
		logic       scan_done;
		logic       found;
		logic       free_found;
		logic       empty;
		logic       full;
		logic       single;
		logic       ref_set;
	} cscr_stat_t;
endpackage

/* sv/cscr_datapath.sv */
module cscr_datapath #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [1:0]           command,
	input  logic [31:0]          key,
	input  cscr_pkg::cscr_cmd_t  cmd,
	output cscr_pkg::cscr_stat_t stat,
	output logic [31:0]          victim_key
);
	import cscr_pkg::*;

	localparam int SW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	logic [KEY_BITS-1:0] key_mem [ENTRIES];
	logic [SW-1:0]       nxt_mem [ENTRIES];
	logic [SW-1:0]       prv_mem [ENTRIES];
	logic [ENTRIES-1:0]  ref_q;
	logic [ENTRIES-1:0]  valid_q;

	logic [1:0]          cmd_q;
	logic [KEY_BITS-1:0] key_q;
	logic [SW-1:0]       head_q, tail_q, hand_q, scan_q, tgt_q, free_q;
	logic [SW-1:0]       p_q, n_q;
	logic                hand_set_q, scan_done_q, found_q, free_found_q;
	logic [CW-1:0]       count_q;
	logic [KEY_BITS-1:0] rd_key_q;
	logic [31:0]         victim_q;
	logic [SW-1:0]       scan_nx;

	logic [KEY_BITS-1:0] key_in;
	generate
		if (KEY_BITS >= 32) begin : g_wide
			assign key_in = KEY_BITS'(key);
			assign victim_key = victim_q;
		end else begin : g_narrow
			assign key_in = key[KEY_BITS-1:0];
			assign victim_key = victim_q;
		end
	endgenerate

	// address of the slot the scan pointer holds after this edge
	always_comb begin
		scan_nx = scan_q;
		if (cmd.scan_start)
			scan_nx = '0;
		else if (cmd.scan_step && scan_q != SW'(ENTRIES - 1))
			scan_nx = scan_q + SW'(1);
	end

	assign stat.command    = cmd_q;
	assign stat.scan_done  = scan_done_q;
	assign stat.found      = found_q;
	assign stat.free_found = free_found_q;
	assign stat.empty      = (count_q == '0);
	assign stat.full       = (count_q == CW'(ENTRIES));
	assign stat.single     = (count_q == CW'(1));
	assign stat.ref_set    = ref_q[hand_q];

	always_ff @(posedge clk) begin
		if (cmd.load)
			key_q <= key_in;
		rd_key_q <= key_mem[scan_nx];
		if (cmd.insert) begin
			key_mem[free_q] <= key_q;
			if (count_q == '0) begin
				nxt_mem[free_q] <= free_q;
				prv_mem[free_q] <= free_q;
			end else begin
				prv_mem[free_q] <= tail_q;
				nxt_mem[free_q] <= nxt_mem[tail_q];
				nxt_mem[tail_q] <= free_q;
				prv_mem[head_q] <= free_q;
			end
		end
		if (cmd.fetch) begin
			p_q <= prv_mem[tgt_q];
			n_q <= nxt_mem[tgt_q];
		end
		if (cmd.unlink && count_q > CW'(1)) begin
			nxt_mem[p_q] <= n_q;
			prv_mem[n_q] <= p_q;
		end
		if (cmd.victim_cap)
			victim_q <= 32'(key_mem[tgt_q]);
		else if (cmd.load)
			victim_q <= '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			ref_q        <= '0;
			cmd_q        <= CMD_ACCESS;
			head_q       <= '0;
			tail_q       <= '0;
			hand_q       <= '0;
			hand_set_q   <= 1'b0;
			count_q      <= '0;
			scan_q       <= '0;
			tgt_q        <= '0;
			free_q       <= '0;
			scan_done_q  <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (cmd.load)
				cmd_q <= command;
			if (cmd.scan_start) begin
				scan_q       <= '0;
				scan_done_q  <= 1'b0;
				found_q      <= 1'b0;
				free_found_q <= 1'b0;
			end
			// one slot per cycle: match and lowest free slot
			if (cmd.scan_step) begin
				if (valid_q[scan_q] && rd_key_q == key_q && !found_q) begin
					found_q <= 1'b1;
					tgt_q   <= scan_q;
				end
				if (!valid_q[scan_q] && !free_found_q) begin
					free_found_q <= 1'b1;
					free_q       <= scan_q;
				end
				if (scan_q == SW'(ENTRIES - 1))
					scan_done_q <= 1'b1;
				else
					scan_q <= scan_q + SW'(1);
			end
			if (cmd.hit_mark)
				ref_q[tgt_q] <= 1'b1;
			if (cmd.insert) begin
				valid_q[free_q] <= 1'b1;
				ref_q[free_q]   <= 1'b1;
				tail_q          <= free_q;
				if (count_q == '0)
					head_q <= free_q;
				count_q <= count_q + CW'(1);
			end
			if (cmd.hand_init) begin
				if (!hand_set_q) begin
					hand_q <= head_q;
					tgt_q  <= head_q;
				end else
					tgt_q <= hand_q;
				hand_set_q <= 1'b1;
			end
			if (cmd.sweep_step) begin
				ref_q[hand_q] <= 1'b0;
				hand_q <= nxt_mem[hand_q];
				tgt_q  <= nxt_mem[hand_q];
			end
			if (cmd.unlink) begin
				valid_q[tgt_q] <= 1'b0;
				if (count_q <= CW'(1)) begin
					hand_set_q <= 1'b0;
					head_q     <= '0;
					tail_q     <= '0;
					hand_q     <= '0;
					count_q    <= '0;
				end else begin
					if (tgt_q == head_q)
						head_q <= n_q;
					else if (tgt_q == tail_q)
						tail_q <= p_q;
					if (hand_set_q && hand_q == tgt_q)
						hand_q <= n_q;
					count_q <= count_q - CW'(1);
				end
			end
		end
	end
endmodule

/* sv/cscr_ctrl.sv */
module cscr_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  cscr_pkg::cscr_stat_t stat,
	output cscr_pkg::cscr_cmd_t  cmd,
	output logic [2:0]           status
);
	import cscr_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SWEEP  = 3'd3;
	localparam logic [2:0] S_FETCH  = 3'd4;
	localparam logic [2:0] S_UNLINK = 3'd5;
	localparam logic [2:0] S_OUT    = 3'd6;

	logic [2:0] state_q, state_d;
	logic [2:0] status_q, status_d;

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign status    = status_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		status_d = status_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load       = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				if (stat.command == CMD_EVICT) begin
					if (stat.empty) begin
						status_d = ST_EMPTY;
						state_d  = S_OUT;
					end else begin
						cmd.hand_init = 1'b1;
						state_d       = stat.single ? S_FETCH : S_SWEEP;
					end
				end else if (stat.command != CMD_ACCESS && stat.command != CMD_REMOVE) begin
					status_d = ST_NOT_FOUND;
					state_d  = S_OUT;
				end else if (stat.scan_done)
					state_d = S_DECIDE;
				else
					cmd.scan_step = 1'b1;
			end
			S_DECIDE: begin
				state_d = S_OUT;
				if (stat.command == CMD_ACCESS) begin
					if (stat.found) begin
						cmd.hit_mark = 1'b1;
						status_d     = ST_HIT;
					end else if (stat.full || !stat.free_found)
						status_d = ST_FULL;
					else begin
						cmd.insert = 1'b1;
						status_d   = ST_INSERTED;
					end
				end else if (stat.found) begin
					cmd.fetch = 1'b1;
					status_d  = ST_REMOVED;
					state_d   = S_UNLINK;
				end else
					status_d = ST_NOT_FOUND;
			end
			S_SWEEP: begin
				// pass over referenced entries, clearing them
				if (stat.ref_set)
					cmd.sweep_step = 1'b1;
				else
					state_d = S_FETCH;
			end
			S_FETCH: begin
				cmd.fetch      = 1'b1;
				cmd.victim_cap = 1'b1;
				status_d       = ST_EVICTED;
				state_d        = S_UNLINK;
			end
			S_UNLINK: begin
				cmd.unlink = 1'b1;
				state_d    = S_OUT;
			end
			S_OUT: begin
				if (!out_stall)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			status_q <= ST_HIT;
		end else begin
			state_q  <= state_d;
			status_q <= status_d;
		end
	end
endmodule

/* sv/clock_second_chance_replacer.sv */
// Sequence: access and remove scan all slots (one slot compared per cycle), then decide;
//   evict sweeps the hand past each referenced entry (at most ENTRIES), then fetches and
//   unlinks the victim, a lone entry with no sweep; empty evict and code three skip the scan.
// Throughput: one word at a time; the next word is taken after the result is delivered.
// Reset: arst_n clears valid marks, reference bits, head, tail, hand and count at once;
//   keys and links are stored without reset and read only after being written.
module clock_second_chance_replacer #(
	parameter int ENTRIES  = 16,
	parameter int KEY_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [31:0] key,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [31:0] victim_key
);
	import cscr_pkg::*;

	cscr_cmd_t  cmd;
	cscr_stat_t stat;

	// controller sequences the lookup scan, hand sweep and unlink
	cscr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd),
		.status    (status)
	);

	// datapath holds the slot table, links and queue pointers
	cscr_datapath #(
		.ENTRIES  (ENTRIES),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.command    (command),
		.key        (key),
		.cmd        (cmd),
		.stat       (stat),
		.victim_key (victim_key)
	);
endmodule

/* verif/clock_second_chance_replacer_tb.sv */
module clock_second_chance_replacer_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import cscr_pkg::*;

	localparam int SLOTS = 16;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] victim_key;
	} reply_t;

	// Shadow of the replacement table; predicts one reply per accepted word.
	class clock_table_sb;
		logic [31:0] keys[SLOTS];
		bit          refb[SLOTS];
		bit          used[SLOTS];
		int          nxt[SLOTS];
		int          prv[SLOTS];
		int          head, tail, hand, count;
		bit          hand_on;
		reply_t      pending[$];
		int          errors;
		int          n_hit, n_ins, n_evict, n_rem, n_miss, n_empty, n_full;

		function new();
			foreach (used[i]) begin
				used[i] = 0; refb[i] = 0; keys[i] = '0; nxt[i] = 0; prv[i] = 0;
			end
			head = 0; tail = 0; hand = 0; count = 0; hand_on = 0; errors = 0;
			n_hit = 0; n_ins = 0; n_evict = 0; n_rem = 0; n_miss = 0;
			n_empty = 0; n_full = 0;
		endfunction

		function int find_slot(logic [31:0] k);
			for (int s = 0; s < SLOTS; s++)
				if (used[s] && keys[s] == k) return s;
			return SLOTS;
		endfunction

		function void drop_slot(int s);
			int p, n;
			if (count <= 1) begin
				hand_on = 0; head = 0; tail = 0; hand = 0; used[s] = 0; count = 0;
				return;
			end
			p = prv[s];
			n = nxt[s];
			if (s == head) head = n;
			else if (s == tail) tail = p;
			if (hand_on && hand == s) hand = n;
			nxt[p] = n;
			prv[n] = p;
			used[s] = 0;
			count--;
		endfunction

		function void note_word(logic [1:0] cmd, logic [31:0] k);
			reply_t r;
			int s, e;
			r.status = ST_NOT_FOUND;
			r.victim_key = '0;
			if (cmd == CMD_ACCESS) begin
				s = find_slot(k);
				if (s < SLOTS) begin
					refb[s] = 1; r.status = ST_HIT;
				end else if (count >= SLOTS) begin
					r.status = ST_FULL;
				end else begin
					e = 0;
					while (used[e]) e++;
					keys[e] = k; refb[e] = 1; used[e] = 1;
					if (count == 0) begin
						nxt[e] = e; prv[e] = e; head = e; tail = e;
					end else begin
						prv[e] = tail; nxt[e] = nxt[tail]; nxt[tail] = e;
						tail = e; prv[head] = e;
					end
					count++;
					r.status = ST_INSERTED;
				end
			end else if (cmd == CMD_EVICT) begin
				if (count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					if (!hand_on) begin
						hand = head; hand_on = 1;
					end
					if (count > 1)
						for (int g = 0; g < 2 * SLOTS + 1; g++) begin
							if (!refb[hand]) break;
							refb[hand] = 0;
							hand = nxt[hand];
						end
					r.victim_key = keys[hand];
					drop_slot(hand);
					r.status = ST_EVICTED;
				end
			end else if (cmd == CMD_REMOVE && count != 0) begin
				s = find_slot(k);
				if (s < SLOTS) begin
					drop_slot(s); r.status = ST_REMOVED;
				end
			end
			case (r.status)
				ST_HIT: n_hit++;
				ST_INSERTED: n_ins++;
				ST_EVICTED: n_evict++;
				ST_REMOVED: n_rem++;
				ST_EMPTY: n_empty++;
				ST_FULL: n_full++;
				default: n_miss++;
			endcase
			pending.push_back(r);
		endfunction

		function void check_reply(logic [2:0] st, logic [31:0] vk);
			reply_t x;
			if (pending.size() == 0) begin
				$error("reply with nothing pending: status %0d victim_key %h", st, vk);
				errors++;
				return;
			end
			x = pending.pop_front();
			if (st !== x.status) begin
				$error("status: expected %0d actual %0d", x.status, st);
				errors++;
			end
			if (vk !== x.victim_key) begin
				$error("victim_key: expected %h actual %h", x.victim_key, vk);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_stall;
	logic [1:0]  command = CMD_ACCESS;
	logic [31:0] key = '0;
	logic        out_valid;
	logic        out_stall = 0;
	logic [2:0]  status;
	logic [31:0] victim_key;

	clock_table_sb sb = new();
	bit calm;        // set during the stretch with no idling
	int words_in;

	always #6 clk = ~clk;

	clock_second_chance_replacer #(.ENTRIES(SLOTS), .KEY_BITS(32)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .key(key),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .victim_key(victim_key)
	);

	// Check every reply word taken at an edge; stall the reply side at random.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_reply(status, victim_key);
			out_stall <= calm ? 1'b0 : ($urandom_range(99) < 22);
		end
	end

	// Send one command word; random gap first, then hold until accepted.
	task automatic send_word(logic [1:0] c, logic [31:0] k);
		while (!calm && $urandom_range(99) < 22)
			@(posedge clk);
		in_valid <= 1'b1;
		command <= c;
		key <= k;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// word taken at this edge
		sb.note_word(c, k);
		words_in++;
		in_valid <= 1'b0;
		// the block is busy past this edge; drop valid before the next word
		@(posedge clk);
	endtask

	// Small key pool so hits and removes of live keys are common.
	function automatic logic [31:0] pool_key();
		logic [31:0] base[8] = '{32'h0, 32'hFFFF_FFFF, 32'h1, 32'h8000_0000,
			32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 32'hFFFF_0000};
		if ($urandom_range(9) < 2) return $urandom();
		if ($urandom_range(2) == 0) return base[$urandom_range(7)];
		return 32'h100 + $urandom_range(23);
	endfunction

	initial begin
		int pick;
		logic [1:0] c;
		calm = 0;
		words_in = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty evict, remove on empty, code three, extremes of key.
		send_word(CMD_EVICT, 32'h0);
		send_word(CMD_REMOVE, 32'h1234);
		send_word(2'd3, 32'hFFFF_FFFF);
		send_word(CMD_ACCESS, 32'hFFFF_FFFF);
		send_word(CMD_EVICT, 32'h0);          // lone entry goes at once
		send_word(CMD_ACCESS, 32'h0);
		send_word(CMD_ACCESS, 32'h0);         // hit
		send_word(CMD_REMOVE, 32'hDEAD_BEEF); // absent
		send_word(CMD_REMOVE, 32'h0);
		// Fill to capacity, then one more for full.
		for (int i = 0; i < SLOTS; i++)
			send_word(CMD_ACCESS, 32'hA000_0000 + i);
		send_word(CMD_ACCESS, 32'h5A5A_5A5A);
		send_word(CMD_EVICT, 32'h0);          // full sweep clears all bits
		send_word(CMD_REMOVE, 32'hA000_0001); // entry under the hand
		send_word(CMD_EVICT, 32'hFFFF_FFFF);

		// Random: weighted toward access to keep the table busy.
		for (int i = 0; i < 600; i++) begin
			calm = (i >= 250 && i < 350);
			pick = $urandom_range(99);
			if (pick < 50) c = CMD_ACCESS;
			else if (pick < 75) c = CMD_EVICT;
			else if (pick < 96) c = CMD_REMOVE;
			else c = 2'd3;
			send_word(c, pool_key());
		end
		calm = 0;

		// Drain, then allow one more latency window.
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (3 * SLOTS) @(posedge clk);
		$display("sent %0d words: %0d hit, %0d inserted, %0d evicted, %0d removed",
			words_in, sb.n_hit, sb.n_ins, sb.n_evict, sb.n_rem);
		$display("also %0d not found, %0d empty, %0d full replies",
			sb.n_miss, sb.n_empty, sb.n_full);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("** clock_second_chance_replacer: PASSED **");
		else
			$display("** clock_second_chance_replacer: FAILED **");
		$finish;
	end

	initial begin
		#5ms;
		$display("** clock_second_chance_replacer: FAILED **");
		$finish;
	end
endmodule

/* filelist.f */
sv/cscr_pkg.sv
sv/cscr_datapath.sv
sv/cscr_ctrl.sv
sv/clock_second_chance_replacer.sv
verif/clock_second_chance_replacer_tb.sv
